// File: src/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared constants for the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbpe_pkg;

	// default coordinate width and segment limit
	localparam int COORD_WIDTH_DEF  = 16;
	localparam int MAX_SEGMENTS_DEF = 4096;

	// fixed field widths
	localparam int IDX_W   = 13;
	localparam int REG_W   = 48;
	localparam int CFG_A_W = 3;

	// register indexes
	localparam logic [CFG_A_W-1:0] REG_POINT_ONE   = 3'd0;
	localparam logic [CFG_A_W-1:0] REG_POINT_TWO   = 3'd1;
	localparam logic [CFG_A_W-1:0] REG_POINT_THREE = 3'd2;
	localparam logic [CFG_A_W-1:0] REG_POINT_FOUR  = 3'd3;
	localparam logic [CFG_A_W-1:0] REG_SEGMENTS    = 3'd4;

	localparam logic [IDX_W-1:0] SEG_RESET = 13'd16;

endpackage

// File: src/cubic_bezier_point_evaluator_top.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_evaluator_top
// Curve point at t = i/S from Bernstein weights, exact rounded division.
// ----------------------------------------------------------------------------
//  channel  | signals                                 | direction
//  in       | in_valid, in_ready, sample_index        | request in
//  out      | out_valid, out_ready, x/y/z_coord, flags| request out
//  cfg      | cfg_we, cfg_index, cfg_data             | write only
//
// One request per cycle while the output is not stalled. The restoring
// divider resolves one quotient bit per stage.
// The whole pipeline advances together; a stalled output holds every stage.
// Reset clears the valid bits and loads the reset register values.
// ----------------------------------------------------------------------------
module cubic_bezier_point_evaluator_top #(
	parameter int COORD_WIDTH  = cbpe_pkg::COORD_WIDTH_DEF,
	parameter int MAX_SEGMENTS = cbpe_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [cbpe_pkg::IDX_W-1:0]   sample_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_WIDTH-1:0] x_coord,
	output logic signed [COORD_WIDTH-1:0] y_coord,
	output logic signed [COORD_WIDTH-1:0] z_coord,
	output logic                         last_sample,
	output logic                         out_of_range,
	input  logic                         cfg_we,
	input  logic [cbpe_pkg::CFG_A_W-1:0] cfg_index,
	input  logic [cbpe_pkg::REG_W-1:0]   cfg_data
);

	localparam int W   = COORD_WIDTH;
	localparam int SW  = $clog2(MAX_SEGMENTS + 1);
	localparam int WW  = 3 * SW;
	localparam int PW  = WW + W;
	localparam int NW  = PW + 2;
	localparam int XW  = (3 * W > cbpe_pkg::REG_W) ? 3 * W : cbpe_pkg::REG_W;
	localparam logic [W-1:0] CSIGN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] CMAX  = {W{1'b1}};

	logic                        en;
	logic [cbpe_pkg::REG_W-1:0]  point_q [4];
	logic [cbpe_pkg::IDX_W-1:0]  seg_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) point_q[k] <= '0;
			seg_q <= cbpe_pkg::SEG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cbpe_pkg::REG_POINT_ONE:   point_q[0] <= cfg_data;
				cbpe_pkg::REG_POINT_TWO:   point_q[1] <= cfg_data;
				cbpe_pkg::REG_POINT_THREE: point_q[2] <= cfg_data;
				cbpe_pkg::REG_POINT_FOUR:  point_q[3] <= cfg_data;
				cbpe_pkg::REG_SEGMENTS:    seg_q      <= cfg_data[cbpe_pkg::IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// offset binary coordinates of each control point
	logic [W-1:0] coord [3][4];
	always_comb begin
		logic [XW-1:0] ext;
		for (int k = 0; k < 4; k++) begin
			ext = XW'(point_q[k]);
			for (int ax = 0; ax < 3; ax++) coord[ax][k] = ext[ax*W +: W] ^ CSIGN;
		end
	end

	// global advance: move when the output is free or taken
	assign en       = out_ready || !out_valid;
	assign in_ready = en;

	// stage 1: effective segment count and range flags
	logic [SW-1:0] seg_eff, idx_eff;
	logic          oor_c, last_c;
	always_comb begin
		if (seg_q == '0) seg_eff = SW'(1);
		else if (32'(seg_q) > 32'(MAX_SEGMENTS)) seg_eff = SW'(MAX_SEGMENTS);
		else seg_eff = SW'(seg_q);
		oor_c   = 32'(sample_index) > 32'(seg_eff);
		last_c  = 32'(sample_index) == 32'(seg_eff);
		idx_eff = oor_c ? '0 : SW'(sample_index);
	end

	logic          v_s1, oor_s1, last_s1;
	logic [SW-1:0] i_s1, s_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			i_s1    <= idx_eff;
			s_s1    <= seg_eff;
			oor_s1  <= oor_c;
			last_s1 <= last_c;
		end
	end

	// stage 2: squares and cross product
	logic            v_s2, oor_s2, last_s2;
	logic [SW-1:0]   a_s2, i_s2, s_s2;
	logic [2*SW-1:0] aa_s2, ii_s2, ai_s2, ss_s2;
	logic [SW-1:0]   a_c;
	assign a_c = s_s1 - i_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2    <= a_c;
			i_s2    <= i_s1;
			s_s2    <= s_s1;
			aa_s2   <= (2*SW)'(a_c) * (2*SW)'(a_c);
			ii_s2   <= (2*SW)'(i_s1) * (2*SW)'(i_s1);
			ai_s2   <= (2*SW)'(a_c) * (2*SW)'(i_s1);
			ss_s2   <= (2*SW)'(s_s1) * (2*SW)'(s_s1);
			oor_s2  <= oor_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: Bernstein weights and divisor
	logic          v_s3, oor_s3, last_s3;
	logic [WW-1:0] w_s3 [4];
	logic [WW-1:0] d_s3;
	logic [WW-1:0] aai_c, aii_c;
	assign aai_c = WW'(aa_s2) * WW'(i_s2);
	assign aii_c = WW'(ai_s2) * WW'(i_s2);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			w_s3[0] <= WW'(aa_s2) * WW'(a_s2);
			w_s3[1] <= WW'({aai_c, 1'b0} + {1'b0, aai_c});
			w_s3[2] <= WW'({aii_c, 1'b0} + {1'b0, aii_c});
			w_s3[3] <= WW'(ii_s2) * WW'(i_s2);
			d_s3    <= WW'(ss_s2) * WW'(s_s2);
			oor_s3  <= oor_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: weighted coordinates
	logic          v_s4, oor_s4, last_s4;
	logic [PW-1:0] p_s4 [3][4];
	logic [WW-1:0] d_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ax = 0; ax < 3; ax++)
				for (int k = 0; k < 4; k++)
					p_s4[ax][k] <= PW'(w_s3[k]) * PW'(coord[ax][k]);
			d_s4    <= d_s3;
			oor_s4  <= oor_s3;
			last_s4 <= last_s3;
		end
	end

	// stage 5: numerator sums, bounded by d times 2^W
	logic          v_s5, oor_s5, last_s5;
	logic [PW-1:0] n_s5 [3];
	logic [WW-1:0] d_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ax = 0; ax < 3; ax++)
				n_s5[ax] <= PW'(NW'(p_s4[ax][0]) + NW'(p_s4[ax][1])
					+ NW'(p_s4[ax][2]) + NW'(p_s4[ax][3]));
			d_s5    <= d_s4;
			oor_s5  <= oor_s4;
			last_s5 <= last_s4;
		end
	end

	// divider stages: one quotient bit per stage, most significant first
	logic          v_sd    [W+1];
	logic          oor_sd  [W+1];
	logic          last_sd [W+1];
	logic [WW-1:0] d_sd    [W+1];
	logic [PW-1:0] rem_sd  [W+1][3];
	logic [W-1:0]  q_sd    [W+1][3];

	assign v_sd[0]    = v_s5;
	assign oor_sd[0]  = oor_s5;
	assign last_sd[0] = last_s5;
	assign d_sd[0]    = d_s5;
	for (genvar ax = 0; ax < 3; ax++) begin : g_dz
		assign rem_sd[0][ax] = n_s5[ax];
		assign q_sd[0][ax]   = '0;
	end

	for (genvar j = 0; j < W; j++) begin : g_div
		localparam int B = W - 1 - j;
		logic [PW-1:0] dsh;
		assign dsh = PW'(d_sd[j]) << B;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sd[j+1] <= 1'b0;
			else if (en) v_sd[j+1] <= v_sd[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int ax = 0; ax < 3; ax++) begin
					if (rem_sd[j][ax] >= dsh) begin
						rem_sd[j+1][ax] <= rem_sd[j][ax] - dsh;
						q_sd[j+1][ax]   <= q_sd[j][ax] | (W'(1) << B);
					end else begin
						rem_sd[j+1][ax] <= rem_sd[j][ax];
						q_sd[j+1][ax]   <= q_sd[j][ax];
					end
				end
				d_sd[j+1]    <= d_sd[j];
				oor_sd[j+1]  <= oor_sd[j];
				last_sd[j+1] <= last_sd[j];
			end
		end
	end

	// final stage: round half up, clamp, back to two's complement, zero when out of range
	logic [W-1:0] res_c [3];
	always_comb begin
		logic [W:0] qr;
		for (int ax = 0; ax < 3; ax++) begin
			qr = {1'b0, q_sd[W][ax]};
			if ({1'b0, rem_sd[W][ax]} >= (PW+1)'(d_sd[W]) - {1'b0, rem_sd[W][ax]})
				qr = qr + (W+1)'(1);
			if (qr[W]) res_c[ax] = CMAX ^ CSIGN;
			else res_c[ax] = qr[W-1:0] ^ CSIGN;
			if (oor_sd[W]) res_c[ax] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_sd[W];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_coord      <= res_c[0];
			y_coord      <= res_c[1];
			z_coord      <= res_c[2];
			last_sample  <= last_sd[W] && !oor_sd[W];
			out_of_range <= oor_sd[W];
		end
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Request-level test of the cubic Bezier point evaluator: directed corners,
// random control points, segment counts and sampling, output back-pressure,
// each result checked against an exact rational predictor of the curve.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CW       = cbpe_pkg::COORD_WIDTH_DEF;
	localparam int MAX_SEG  = cbpe_pkg::MAX_SEGMENTS_DEF;
	localparam int IW       = cbpe_pkg::IDX_W;
	localparam int RW       = cbpe_pkg::REG_W;
	localparam int AW       = cbpe_pkg::CFG_A_W;
	localparam int LAT      = 6 + CW;
	localparam int WD_LIMIT = 4000;
	localparam logic [CW-1:0]  SIGN_BIT = {1'b1, {(CW-1){1'b0}}};
	localparam logic [127:0]   Q_MAX    = 128'((64'd1 << CW) - 64'd1);

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 last;
		logic                 oor;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [IW-1:0] sample_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CW-1:0] x_coord, y_coord, z_coord;
	logic last_sample, out_of_range;
	logic cfg_we = 1'b0;
	logic [AW-1:0] cfg_index = '0;
	logic [RW-1:0] cfg_data = '0;

	// shadow registers for the predictor
	logic [RW-1:0] ctrl_pt [4];
	logic [IW-1:0] seg_count;

	point_t expected_points [$];
	int errors = 0;
	int n_checked = 0;
	int n_last = 0;
	int n_oor = 0;
	int idle_cycles = 0;
	bit rx_busy = 1'b1;
	bit rx_hold = 1'b0;
	bit calm = 1'b0;

	cubic_bezier_point_evaluator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample_index(sample_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
		.last_sample(last_sample), .out_of_range(out_of_range),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// one coordinate: exact weighted sum over s^3, rounded half up, saturated
	function automatic logic signed [CW-1:0] bezier_axis(input logic [63:0] wt [4],
			input logic [63:0] den, input int axis);
		logic [127:0] acc;
		logic [127:0] q;
		logic [127:0] rem;
		logic [CW-1:0] c;
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			c = ctrl_pt[k][axis*CW +: CW] ^ SIGN_BIT;
			acc += 128'(wt[k]) * 128'(c);
		end
		q = acc / 128'(den);
		rem = acc % 128'(den);
		if (rem >= 128'(den) - rem) q++;
		if (q > Q_MAX) q = Q_MAX;
		return q[CW-1:0] ^ SIGN_BIT;
	endfunction

	function automatic point_t curve_point(input logic [IW-1:0] idx);
		point_t p;
		logic [63:0] s, i, a, den;
		logic [63:0] wt [4];
		s = 64'(seg_count);
		i = 64'(idx);
		if (s == 64'd0) s = 64'd1;
		if (s > 64'(MAX_SEG)) s = 64'(MAX_SEG);
		p = '0;
		if (i > s) begin
			p.oor = 1'b1;
			return p;
		end
		a = s - i;
		wt[0] = a * a * a;
		wt[1] = 64'd3 * a * a * i;
		wt[2] = 64'd3 * a * i * i;
		wt[3] = i * i * i;
		den = s * s * s;
		p.x = bezier_axis(wt, den, 0);
		p.y = bezier_axis(wt, den, 1);
		p.z = bezier_axis(wt, den, 2);
		p.last = (i == s);
		return p;
	endfunction

	// send one sample request, waiting for acceptance
	task automatic send_sample(input logic [IW-1:0] idx);
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_index <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_points = {expected_points, curve_point(idx)};
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [AW-1:0] idx, input logic [RW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		if (idx == cbpe_pkg::REG_SEGMENTS) seg_count = val[IW-1:0];
		else ctrl_pt[idx[1:0]] = val;
	endtask

	// wait for the pipe to empty before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_points.size() != 0) @(negedge clk);
		repeat (LAT + 4) @(negedge clk);
	endtask

	task automatic set_curve(input logic [RW-1:0] p0, p1, p2, p3,
			input logic [IW-1:0] s);
		drain();
		write_reg(cbpe_pkg::REG_POINT_ONE, p0);
		write_reg(cbpe_pkg::REG_POINT_TWO, p1);
		write_reg(cbpe_pkg::REG_POINT_THREE, p2);
		write_reg(cbpe_pkg::REG_POINT_FOUR, p3);
		write_reg(cbpe_pkg::REG_SEGMENTS, RW'(s));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [RW-1:0] rand_point();
		return RW'({$urandom(), $urandom()});
	endfunction

	// effective segment count as the block sees it
	function automatic logic [IW-1:0] seg_eff();
		if (seg_count == '0) return IW'(1);
		if (32'(seg_count) > MAX_SEG) return IW'(MAX_SEG);
		return seg_count;
	endfunction

	// reset values, then every index edge and segment count edge
	task automatic test_directed();
		sample_index_edges();
		set_curve(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_8000_7FFF,
			48'h8000_7FFF_8000, 13'd3);
		sample_index_edges();
		set_curve(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
			48'h7FFF_7FFF_7FFF, 13'd0);
		sample_index_edges();
		set_curve(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
			48'h8000_8000_8000, 13'd4096);
		sample_index_edges();
		set_curve(48'h0100_FF00_1234, 48'hFFFF_FFFF_FFFF, 48'h5555_AAAA_0001,
			48'h0000_0000_0000, 13'd8191);
		sample_index_edges();
	endtask

	task automatic sample_index_edges();
		logic [IW-1:0] s;
		s = seg_eff();
		send_sample(IW'(0));
		send_sample(IW'(1));
		send_sample(s - IW'(1));
		send_sample(s);
		send_sample(s + IW'(1));
	endtask

	// random curves with mostly in-range indices, a few past the end
	task automatic test_random(input int n);
		logic [IW-1:0] s;
		for (int k = 0; k < n; k++) begin
			if (k % 100 == 0) begin
				case ($urandom_range(3))
					0: s = IW'($urandom_range(16, 1));
					1: s = IW'($urandom_range(4096, 1));
					2: s = IW'($urandom_range(8191, 4097));
					default: s = IW'($urandom_range(300, 0));
				endcase
				set_curve(rand_point(), rand_point(), rand_point(), rand_point(), s);
			end
			calm = (k % 100) >= 70;
			s = seg_eff();
			if ($urandom_range(9) == 0) send_sample(IW'($urandom()));
			else if ($urandom_range(9) == 0) send_sample(s);
			else send_sample(IW'($urandom_range(32'(s), 0)));
		end
		calm = 1'b0;
	endtask

	// receiver holds off while requests keep coming, so the pipe backs up
	task automatic test_backpressure();
		set_curve(rand_point(), rand_point(), rand_point(), rand_point(), 13'd64);
		rx_hold = 1'b1;
		calm = 1'b1;
		fork
			begin
				repeat (200) @(negedge clk);
				rx_hold = 1'b0;
			end
			for (int k = 0; k < 60; k++) send_sample(IW'($urandom_range(64, 0)));
		join
		calm = 1'b0;
	endtask

	// receiver ready pattern
	always @(negedge clk) begin
		if (rx_hold) out_ready <= 1'b0;
		else if (calm) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(99) >= 36);
	end

	// result check
	always @(posedge clk) begin
		point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				want = expected_points.pop_front();
				n_checked++;
				if (want.last) n_last++;
				if (want.oor) n_oor++;
				if (x_coord !== want.x) begin
					$error("x_coord exp %0d got %0d", want.x, x_coord); errors++;
				end
				if (y_coord !== want.y) begin
					$error("y_coord exp %0d got %0d", want.y, y_coord); errors++;
				end
				if (z_coord !== want.z) begin
					$error("z_coord exp %0d got %0d", want.z, z_coord); errors++;
				end
				if (last_sample !== want.last) begin
					$error("last_sample exp %0b got %0b", want.last, last_sample); errors++;
				end
				if (out_of_range !== want.oor) begin
					$error("out_of_range exp %0b got %0b", want.oor, out_of_range); errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !rx_busy) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("watchdog expired");
			$display("FAIL cubic_bezier_point_evaluator_top");
			$finish;
		end
	end

	// test sequence
	initial begin
		for (int k = 0; k < 4; k++) ctrl_pt[k] = '0;
		seg_count = cbpe_pkg::SEG_RESET;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random(1220);
		drain();
		rx_busy = 1'b0;
		$display("checked %0d points, %0d end samples, %0d past the end",
			n_checked, n_last, n_oor);
		if (errors == 0 && expected_points.size() == 0)
			$display("PASS cubic_bezier_point_evaluator_top");
		else
			$display("FAIL cubic_bezier_point_evaluator_top");
		$finish;
	end

endmodule

// File: sim.f
src/cbpe_pkg.sv
src/cubic_bezier_point_evaluator_top.sv
dv/tb_top.sv
